>>> rtl/core/palette_pixel_expand_alpha_mask_unit_defines.svh
// Assertion macros for the palette pixel expander
`ifndef PALETTE_PIXEL_EXPAND_ALPHA_MASK_UNIT_DEFINES_SVH
`define PALETTE_PIXEL_EXPAND_ALPHA_MASK_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PPE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PPE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/ppe_pkg.sv
// Shared constants and types for the palette pixel expander
`timescale 1ns / 1ps

package ppe_pkg;

	localparam int PALETTE_DEPTH = 1024;
	localparam int ADDR_W        = $clog2(PALETTE_DEPTH);
	// pixel index (8 bits) plus base (10 bits) needs 11 bits before wrapping
	localparam int SUM_W         = (ADDR_W > 11) ? ADDR_W : 11;

	localparam int BASE_W        = 10;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 10;

	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_WRITE = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_BASE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_USE_PALETTE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MASK_ENABLE  = 2'd2;

	typedef struct packed {
		logic [31:0] pixel;
		logic        use_pal;
		logic        mask_en;
	} pix_info_t;

	typedef struct packed {
		logic              busy;
		logic [ADDR_W-1:0] addr;
	} clr_t;

endpackage

>>> rtl/core/ppe_ram.sv
// Generic simple dual-port RAM with registered read
`timescale 1ns / 1ps

module ppe_ram #(
	parameter int Width = 32,
	parameter int Depth = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/core/ppe_init.sv
// Clearing sequencer that zeroes the palette store after reset
`timescale 1ns / 1ps

module ppe_init (
	input  logic          clk,
	input  logic          arst_n,
	output ppe_pkg::clr_t clr
);

	import ppe_pkg::*;

	logic              busy_q;
	logic [ADDR_W-1:0] addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			addr_q <= '0;
		end else if (busy_q) begin
			addr_q <= addr_q + ADDR_W'(1);
			if (addr_q == ADDR_W'(PALETTE_DEPTH - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign clr.busy = busy_q;
	assign clr.addr = addr_q;

endmodule

>>> rtl/core/ppe_blend.sv
// Alpha modulation stages and output register
`timescale 1ns / 1ps

module ppe_blend (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s1_valid,
	input  ppe_pkg::pix_info_t s1_info,
	input  logic [31:0]        color,
	output logic               s1_take,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [31:0]        out_pixel,
	output logic [7:0]         mask_alpha,
	output logic               mask_valid
);

	import ppe_pkg::*;

	logic        s2_valid_q;
	logic [15:0] prod_s2;
	logic [23:0] rgb_s2;
	pix_info_t   info_s2;

	logic        out_valid_q;
	logic [31:0] out_pixel_q;
	logic [7:0]  mask_alpha_q;
	logic        mask_valid_q;

	logic        out_en;
	logic [16:0] div_sum;
	logic [7:0]  alpha_mod;

	assign out_en  = !out_valid_q || !out_stall;
	assign s1_take = !s2_valid_q || out_en;

	// floor(p / 255) for p up to 65025 (255 * 255): (p + (p >> 8) + 1) >> 8
	assign div_sum   = 17'(prod_s2) + 17'(prod_s2[15:8]) + 17'd1;
	assign alpha_mod = div_sum[15:8];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_take) begin
				s2_valid_q <= s1_valid;
			end
			if (out_en) begin
				out_valid_q <= s2_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_take) begin
			prod_s2 <= 16'(color[31:24] * s1_info.pixel[31:24]);
			rgb_s2  <= color[23:0];
			info_s2 <= s1_info;
		end
		if (out_en) begin
			out_pixel_q  <= info_s2.use_pal ? {alpha_mod, rgb_s2} : info_s2.pixel;
			mask_alpha_q <= info_s2.pixel[31:24];
			mask_valid_q <= info_s2.mask_en;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_pixel  = out_pixel_q;
	assign mask_alpha = mask_alpha_q;
	assign mask_valid = mask_valid_q;

endmodule

>>> rtl/core/palette_pixel_expand_alpha_mask_unit.sv
// Top level of the palette pixel expander with alpha modulation
//
//  channel | handshake             | payload
//  --------+-----------------------+---------------------------------------------
//  in      | in_valid / in_stall   | kind, pixel_word, write_index, write_color
//  out     | out_valid / out_stall | out_pixel, mask_alpha, mask_valid
//  cfg     | cfg_we                | cfg_index, cfg_data
//
// One item per cycle while in_stall is low; a pixel passes the palette RAM read,
// the multiply, then divide-by-255 into the output register before out_valid.
// Palette writes go straight to the RAM and give no result.
// After reset the palette RAM is zeroed one entry a cycle, all PALETTE_DEPTH
// (1024) entries, with in_stall high; cfg writes are taken throughout.
// out_stall backs up through the stages; in_stall rises when stage 2 holds a pixel
// and the output register is full and stalled.
`timescale 1ns / 1ps

`include "palette_pixel_expand_alpha_mask_unit_defines.svh"

module palette_pixel_expand_alpha_mask_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [ppe_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ppe_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             kind,
	input  logic [31:0]                      pixel_word,
	input  logic [9:0]                       write_index,
	input  logic [31:0]                      write_color,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [31:0]                      out_pixel,
	output logic [7:0]                       mask_alpha,
	output logic                             mask_valid
);

	import ppe_pkg::*;

	logic [BASE_W-1:0] palette_base_q;
	logic              use_palette_q;
	logic              mask_enable_q;

	clr_t              clr;
	logic              s1_take;
	logic              accept;
	logic              s1_valid_q;
	pix_info_t         s1_info_q;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [31:0]       ram_wdata;
	logic              ram_re;
	logic [SUM_W-1:0]  rd_sum;
	logic [SUM_W-1:0]  wr_ext;
	logic [31:0]       ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			palette_base_q <= '0;
			use_palette_q  <= 1'b1;
			mask_enable_q  <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PALETTE_BASE: palette_base_q <= cfg_data[BASE_W-1:0];
				CFG_USE_PALETTE:  use_palette_q  <= cfg_data[0];
				CFG_MASK_ENABLE:  mask_enable_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	ppe_init u_init (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (clr)
	);

	assign in_stall = clr.busy || !s1_take;
	assign accept   = in_valid && !in_stall;

	// wrap both addresses round the store
	assign rd_sum = SUM_W'(palette_base_q) + SUM_W'(pixel_word[7:0]);
	assign wr_ext = SUM_W'(write_index);

	assign ram_re    = accept && (kind == KIND_PIXEL);
	assign ram_we    = clr.busy || (accept && (kind == KIND_WRITE));
	assign ram_waddr = clr.busy ? clr.addr : wr_ext[ADDR_W-1:0];
	assign ram_wdata = clr.busy ? 32'd0 : write_color;

	ppe_ram #(
		.Width (32),
		.Depth (PALETTE_DEPTH)
	) u_palette (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (rd_sum[ADDR_W-1:0]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s1_take) begin
			s1_valid_q <= ram_re;
		end
	end

	always_ff @(posedge clk) begin
		if (ram_re) begin
			s1_info_q.pixel   <= pixel_word;
			s1_info_q.use_pal <= use_palette_q;
			s1_info_q.mask_en <= mask_enable_q;
		end
	end

	ppe_blend u_blend (
		.clk        (clk),
		.arst_n     (arst_n),
		.s1_valid   (s1_valid_q),
		.s1_info    (s1_info_q),
		.color      (ram_rdata),
		.s1_take    (s1_take),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_pixel  (out_pixel),
		.mask_alpha (mask_alpha),
		.mask_valid (mask_valid)
	);

	`PPE_ASSERT_NOW(a_no_xfer_while_clearing, clk, arst_n, clr.busy, in_stall, "transfer during clear")
	`PPE_ASSERT_NOW(a_no_pixel_while_clearing, clk, arst_n, s1_valid_q, !clr.busy, "pixel during clear")
	`PPE_ASSERT_NOW(a_single_ram_access, clk, arst_n, ram_re, !ram_we, "read and write together")
	`PPE_ASSERT_NEXT(a_write_no_result, clk, arst_n, accept && (kind == KIND_WRITE), !s1_valid_q, "write entered pipe")

endmodule

>>> bench/palette_pixel_expand_alpha_mask_unit_tb.sv
// Self-checking testbench for the palette pixel expander with alpha modulation
`timescale 1ns / 1ps

module palette_pixel_expand_alpha_mask_unit_tb;
	import ppe_pkg::*;

	localparam int CLK_PERIOD     = 12;
	localparam int RESET_CYCLES   = 12;
	localparam int IDLE_PCT       = 18;
	localparam int LATENCY_PAD    = 8;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASE_ITEMS    = 110;
	localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

	typedef struct packed {
		logic [31:0] pixel;
		logic [7:0]  alpha;
		logic        mask_v;
	} expanded_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic                  kind;
	logic [31:0]           pixel_word;
	logic [9:0]            write_index;
	logic [31:0]           write_color;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [31:0]           out_pixel;
	logic [7:0]            mask_alpha;
	logic                  mask_valid;

	// shadow of the block's palette and registers
	logic [31:0]     palette_shadow [PALETTE_DEPTH];
	logic [BASE_W-1:0] base_shadow;
	logic            use_pal_shadow;
	logic            mask_en_shadow;

	expanded_t pending_pixels[$];
	int        mismatch_count = 0;
	int        quiet_cycles = 0;
	bit        steady = 1'b0;

	palette_pixel_expand_alpha_mask_unit u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.pixel_word  (pixel_word),
		.write_index (write_index),
		.write_color (write_color),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_pixel   (out_pixel),
		.mask_alpha  (mask_alpha),
		.mask_valid  (mask_valid)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	function automatic expanded_t expand_pixel_expected(input logic [31:0] px);
		expanded_t   res;
		int unsigned row;
		logic [31:0] colour;
		logic [15:0] product;
		row = (int'(base_shadow) + int'(px[7:0])) % PALETTE_DEPTH;
		colour = palette_shadow[row];
		product = colour[31:24] * px[31:24];
		if (use_pal_shadow)
			res.pixel = {8'(product / 16'd255), colour[23:0]};
		else
			res.pixel = px;
		res.alpha = px[31:24];
		res.mask_v = mask_en_shadow;
		return res;
	endfunction

	// Output side: random stall, result check and watchdog
	always @(posedge clk) begin
		expanded_t want;
		bit moved;
		moved = (in_valid && !in_stall) || (out_valid && !out_stall);
		if (out_valid && !out_stall) begin
			if (pending_pixels.size() == 0) begin
				$display("%0t: unexpected result out_pixel=%h mask_alpha=%h mask_valid=%b",
					$time, out_pixel, mask_alpha, mask_valid);
				mismatch_count++;
			end else begin
				want = pending_pixels.pop_front();
				if (out_pixel !== want.pixel) begin
					$display("%0t: out_pixel expected %h actual %h", $time, want.pixel, out_pixel);
					mismatch_count++;
				end
				if (mask_alpha !== want.alpha) begin
					$display("%0t: mask_alpha expected %h actual %h", $time, want.alpha, mask_alpha);
					mismatch_count++;
				end
				if (mask_valid !== want.mask_v) begin
					$display("%0t: mask_valid expected %b actual %b", $time, want.mask_v, mask_valid);
					mismatch_count++;
				end
			end
		end
		out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
		quiet_cycles = moved ? 0 : quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transfer for %0d cycles, %0d results outstanding",
				$time, quiet_cycles, pending_pixels.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Drive one item and hold it until the transfer; predict at the transfer edge
	task automatic send_item(input logic k, input logic [31:0] px,
			input logic [9:0] widx, input logic [31:0] wcol);
		in_valid <= 1'b1;
		kind <= k;
		pixel_word <= px;
		write_index <= widx;
		write_color <= wcol;
		do @(posedge clk); while (in_stall);
		if (k == KIND_WRITE)
			palette_shadow[int'(widx) % PALETTE_DEPTH] = wcol;
		else
			pending_pixels.insert(pending_pixels.size(), expand_pixel_expected(px));
		if (!steady && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < IDLE_PCT) @(posedge clk);
		end
	endtask

	task automatic send_pixel(input logic [31:0] px);
		send_item(KIND_PIXEL, px, 10'($urandom), $urandom);
	endtask

	task automatic send_write(input logic [9:0] widx, input logic [31:0] wcol);
		send_item(KIND_WRITE, $urandom, widx, wcol);
	endtask

	// Stop sending, let every result come back, then let palette writes settle
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (LATENCY_PAD) @(posedge clk);
	endtask

	task automatic set_config(input logic [BASE_W-1:0] base, input logic use_pal,
			input logic mask_en);
		logic [CFG_DATA_W-1:0] junk;
		junk = CFG_DATA_W'($urandom);
		cfg_we <= 1'b1;
		cfg_index <= CFG_PALETTE_BASE;
		cfg_data <= base;
		@(posedge clk);
		// upper data bits are don't-care for the one-bit registers
		cfg_index <= CFG_USE_PALETTE;
		cfg_data <= {junk[CFG_DATA_W-1:1], use_pal};
		@(posedge clk);
		cfg_index <= CFG_MASK_ENABLE;
		cfg_data <= {junk[CFG_DATA_W-2:0], mask_en};
		@(posedge clk);
		cfg_we <= 1'b0;
		base_shadow = base;
		use_pal_shadow = use_pal;
		mask_en_shadow = mask_en;
	endtask

	task automatic test_directed_lookup();
		// empty palette reads back as zero
		send_pixel(32'hFF0000AB);
		send_write(10'd0, 32'hFFFFFFFF);
		send_write(10'd255, 32'h80123456);
		send_write(10'd1023, 32'h7FA5A5A5);
		send_write(10'd16, 32'h00FFFFFF);
		send_pixel(32'hFF000000);
		send_pixel(32'h00FFFF00);
		send_pixel(32'hFFABCDFF);
		send_pixel(32'h7F0000FF);
		send_pixel(32'h80000010);
		// write then read the same row on consecutive transfers
		steady = 1'b1;
		send_write(10'd5, 32'hC0112233);
		send_pixel(32'hC0000005);
		send_write(10'd5, 32'h40AABBCC);
		send_pixel(32'hFF000005);
		steady = 1'b0;
		wait_drained();
	endtask

	task automatic test_wrap();
		set_config(10'd1023, 1'b1, 1'b1);
		send_write(10'd254, 32'hE0C0FFEE);
		send_pixel(32'hFF000000);
		send_pixel(32'h80000001);
		send_pixel(32'hFF0000FF);
		wait_drained();
		set_config(10'd768, 1'b1, 1'b0);
		send_write(10'd768, 32'hFF0F0F0F);
		send_pixel(32'hFF0000FF);
		send_pixel(32'h01000000);
		wait_drained();
	endtask

	task automatic test_passthrough();
		logic [CFG_DATA_W-1:0] junk;
		set_config(10'd0, 1'b0, 1'b0);
		send_pixel(32'h00000000);
		send_pixel(32'hFFFFFFFF);
		send_write(10'd0, 32'h12345678);
		send_pixel(32'h12345600);
		wait_drained();
		// unmapped register index: settings must stay as they were
		junk = CFG_DATA_W'($urandom) | 10'h001;
		cfg_we <= 1'b1;
		cfg_index <= CFG_UNMAPPED;
		cfg_data <= junk;
		@(posedge clk);
		cfg_we <= 1'b0;
		send_pixel(32'hA5A5A5A5);
		send_pixel(32'h5A5A5A00);
		wait_drained();
	endtask

	task automatic run_random_phase(input logic [BASE_W-1:0] base, input logic use_pal,
			input logic mask_en, input bit no_idle, input bit pause_midway);
		logic [31:0] px;
		logic [31:0] wcol;
		logic [9:0]  widx;
		set_config(base, use_pal, mask_en);
		steady = no_idle;
		for (int n = 0; n < PHASE_ITEMS; n++) begin
			if (pause_midway && n == PHASE_ITEMS / 2) begin
				in_valid <= 1'b0;
				while (pending_pixels.size() != 0) @(posedge clk);
			end
			if ($urandom_range(99) < 30) begin
				// favor rows that the current base can reach
				if ($urandom_range(99) < 70)
					widx = 10'((int'(base) + $urandom_range(255)) % PALETTE_DEPTH);
				else
					widx = 10'($urandom);
				wcol = $urandom;
				case ($urandom_range(4))
					0: wcol[31:24] = 8'h00;
					1: wcol[31:24] = 8'hFF;
					default: ;
				endcase
				send_write(widx, wcol);
			end else begin
				px = $urandom;
				case ($urandom_range(4))
					0: px[31:24] = 8'h00;
					1: px[31:24] = 8'hFF;
					default: ;
				endcase
				send_pixel(px);
			end
		end
		steady = 1'b0;
		wait_drained();
	endtask

	task automatic test_random();
		run_random_phase(10'd0, 1'b1, 1'b1, 1'b0, 1'b0);
		run_random_phase(10'd768, 1'b1, 1'b0, 1'b0, 1'b0);
		run_random_phase(10'd1023, 1'b1, 1'b1, 1'b1, 1'b0);
		run_random_phase(10'($urandom), 1'b0, 1'b1, 1'b0, 1'b0);
		run_random_phase(10'($urandom), 1'b1, 1'($urandom), 1'b0, 1'b1);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_PALETTE_BASE;
		cfg_data = '0;
		in_valid = 1'b0;
		kind = KIND_PIXEL;
		pixel_word = '0;
		write_index = '0;
		write_color = '0;
		foreach (palette_shadow[i]) palette_shadow[i] = '0;
		base_shadow = '0;
		use_pal_shadow = 1'b1;
		mask_en_shadow = 1'b1;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_lookup();
		test_wrap();
		test_passthrough();
		test_random();

		if (mismatch_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
